// ===== sv/lps_pkg.sv =====
// Shared types, constants and helpers for the LED pattern sequencer.
// Used by lps_step_mem, lps_ctrl and led_pattern_sequencer; no dependencies.
`default_nettype none

package lps_pkg;

    // Sizing of the LED bank and the pattern table.
    localparam int NUM_LEDS     = 4;
    localparam int NUM_PATTERNS = 8;
    localparam int MAX_STEPS    = 16;

    localparam int LED_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int PAT_W   = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int STEP_W  = $clog2(MAX_STEPS);
    localparam int CNT_W   = $clog2(MAX_STEPS + 1);
    localparam int ADDR_W  = $clog2(NUM_PATTERNS * MAX_STEPS);
    localparam int DEPTH   = NUM_PATTERNS * MAX_STEPS;
    localparam int MS_W    = 16;
    localparam int CD_W    = 20;
    localparam int SCALE_W = 5;
    localparam int OUT_W   = 4;

    // Command codes.
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_WSTEP  = 3'd3;
    localparam logic [2:0] CMD_WHDR   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TICKS = 1'b0;
    localparam logic CFG_MASK  = 1'b1;

    // One step entry of the pattern table.
    typedef struct packed {
        logic            on;
        logic [MS_W-1:0] ms;
    } t_step;

    // Request to the step memory; a request without write enable is a read.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_step             wdata;
    } t_mem_req;

    // Effective configuration seen by the controller.
    typedef struct packed {
        logic [SCALE_W-1:0] tick_scale;
        logic [OUT_W-1:0]   active_high;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [OUT_W-1:0] led_levels;
        logic [OUT_W-1:0] running_mask;
        logic [1:0]       status;
    } t_result;

    // Flat step memory address of a pattern and step.
    function automatic logic [ADDR_W-1:0] step_addr(input logic [PAT_W-1:0]  p,
                                                    input logic [STEP_W-1:0] s);
        step_addr = ADDR_W'(ADDR_W'(p) * ADDR_W'(MAX_STEPS)) + ADDR_W'(s);
    endfunction

endpackage

`default_nettype wire

// ===== sv/lps_step_mem.sv =====
// Step table memory: one synchronous port, read data registered.
// Depends on lps_pkg for the request and entry types.
`default_nettype none

module lps_step_mem (
    input  wire logic              i_clk,
    input  wire lps_pkg::t_mem_req i_req,
    output lps_pkg::t_step         o_rdata
);
    import lps_pkg::*;

    t_step r_mem [DEPTH];
    t_step r_rdata;

    // Write on request; the addressed entry is read into the output register on every request.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/lps_ctrl.sv =====
// Command sequencer: decodes requests, keeps per-LED state and headers,
// and reads or writes the step memory. Depends on lps_pkg.
`default_nettype none

module lps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lps_pkg::t_cfg     i_cfg,
    input  wire logic              i_accept,
    input  wire logic [2:0]        i_cmd,
    input  wire logic [1:0]        i_led_index,
    input  wire logic [2:0]        i_pattern_index,
    input  wire logic [3:0]        i_step_index,
    input  wire logic              i_step_on,
    input  wire logic [15:0]       i_duration_ms,
    input  wire logic [4:0]        i_step_count,
    input  wire logic              i_repeats,
    input  wire logic              i_res_take,
    output logic                   o_idle,
    output logic                   o_res_valid,
    output lps_pkg::t_result       o_res,
    output lps_pkg::t_mem_req      o_mem_req,
    input  wire lps_pkg::t_step    i_mem_rdata
);
    import lps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TICK  = 5'b00010,
        S_TLOAD = 5'b00100,
        S_SLOAD = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [LED_W-1:0]  r_cur, n_cur;
    logic [1:0]        r_status, n_status;

    logic              r_run  [NUM_LEDS], n_run  [NUM_LEDS];
    logic [STEP_W-1:0] r_step [NUM_LEDS], n_step [NUM_LEDS];
    logic [CD_W-1:0]   r_cd   [NUM_LEDS], n_cd   [NUM_LEDS];
    logic [PAT_W-1:0]  r_sel  [NUM_LEDS], n_sel  [NUM_LEDS];
    logic              r_lit  [NUM_LEDS], n_lit  [NUM_LEDS];
    logic [CNT_W-1:0]  r_hcnt [NUM_PATTERNS], n_hcnt [NUM_PATTERNS];
    logic              r_hrep [NUM_PATTERNS], n_hrep [NUM_PATTERNS];

    logic [CD_W-1:0]   load_cd;
    logic [CNT_W-1:0]  nxt;
    logic [PAT_W-1:0]  cur_pat;
    logic              last_led;
    logic [LED_W-1:0]  req_led;
    logic [PAT_W-1:0]  req_pat;
    logic              led_bad;
    logic              pat_bad;
    logic              step_bad;

    // Countdown loaded on entering a step.
    assign load_cd  = CD_W'(i_mem_rdata.ms) * CD_W'(i_cfg.tick_scale);
    assign cur_pat  = r_sel[r_cur];
    assign nxt      = CNT_W'(r_step[r_cur]) + CNT_W'(1);
    assign last_led = (r_cur == LED_W'(NUM_LEDS - 1));
    assign req_led  = LED_W'(i_led_index);
    assign req_pat  = PAT_W'(i_pattern_index);
    assign led_bad  = (int'(i_led_index) >= NUM_LEDS);
    assign pat_bad  = (int'(i_pattern_index) >= NUM_PATTERNS);
    assign step_bad = (int'(i_step_index) >= MAX_STEPS);

    // Next-state logic of the sequencer and the LED and header state.
    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_status = r_status;
        n_run    = r_run;
        n_step   = r_step;
        n_cd     = r_cd;
        n_sel    = r_sel;
        n_lit    = r_lit;
        n_hcnt   = r_hcnt;
        n_hrep   = r_hrep;
        o_mem_req.we    = 1'b0;
        o_mem_req.addr  = step_addr(cur_pat, r_step[r_cur]);
        o_mem_req.wdata = '{on: i_step_on, ms: i_duration_ms};

        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (i_cmd)
                        CMD_TICK: begin
                            n_cur   = '0;
                            n_state = S_TICK;
                        end
                        CMD_START: begin
                            if (led_bad || pat_bad) begin
                                n_status = ST_RANGE;
                            end else if (r_hcnt[req_pat] == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cur          = req_led;
                                n_sel[req_led]  = req_pat;
                                n_step[req_led] = '0;
                                n_run[req_led]  = 1'b1;
                                o_mem_req.addr  = step_addr(req_pat, '0);
                                n_state         = S_SLOAD;
                            end
                        end
                        CMD_STOP: begin
                            if (led_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_run[req_led] = 1'b0;
                            end
                        end
                        CMD_WSTEP: begin
                            if (pat_bad || step_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_mem_req.we   = 1'b1;
                                o_mem_req.addr = step_addr(req_pat, STEP_W'(i_step_index));
                            end
                        end
                        CMD_WHDR: begin
                            if (pat_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_hcnt[req_pat] = (int'(i_step_count) > MAX_STEPS) ?
                                                  CNT_W'(MAX_STEPS) : CNT_W'(i_step_count);
                                n_hrep[req_pat] = i_repeats;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                // Visit one LED per pass; an expiry that enters a new step
                // waits in S_TLOAD for the step entry.
                priority if (r_run[r_cur] && (r_cd[r_cur] > CD_W'(1))) begin
                    n_cd[r_cur] = r_cd[r_cur] - CD_W'(1);
                end else if (r_run[r_cur]) begin
                    n_cd[r_cur] = '0;
                    if ((nxt >= r_hcnt[cur_pat]) && !r_hrep[cur_pat]) begin
                        n_run[r_cur] = 1'b0;
                    end else begin
                        n_step[r_cur] = (nxt >= r_hcnt[cur_pat]) ? '0 : STEP_W'(nxt);
                        o_mem_req.addr = step_addr(cur_pat, n_step[r_cur]);
                    end
                end else begin
                end
                if (r_run[r_cur] && (r_cd[r_cur] <= CD_W'(1)) &&
                    !((nxt >= r_hcnt[cur_pat]) && !r_hrep[cur_pat])) begin
                    n_state = S_TLOAD;
                end else if (last_led) begin
                    n_state = S_DONE;
                end else begin
                    n_cur = r_cur + LED_W'(1);
                end
            end
            S_TLOAD: begin
                n_lit[r_cur] = i_mem_rdata.on;
                n_cd[r_cur]  = load_cd;
                if (last_led) begin
                    n_state = S_DONE;
                end else begin
                    n_cur   = r_cur + LED_W'(1);
                    n_state = S_TICK;
                end
            end
            S_SLOAD: begin
                n_lit[r_cur] = i_mem_rdata.on;
                n_cd[r_cur]  = load_cd;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers; the whole LED and header state resets to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_status <= ST_OK;
            for (int n = 0; n < NUM_LEDS; n++) begin
                r_run[n]  <= 1'b0;
                r_step[n] <= '0;
                r_cd[n]   <= '0;
                r_sel[n]  <= '0;
                r_lit[n]  <= 1'b0;
            end
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                r_hcnt[p] <= '0;
                r_hrep[p] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_status <= n_status;
            r_run    <= n_run;
            r_step   <= n_step;
            r_cd     <= n_cd;
            r_sel    <= n_sel;
            r_lit    <= n_lit;
            r_hcnt   <= n_hcnt;
            r_hrep   <= n_hrep;
        end
    end

    // Result assembly: a lit LED drives its active level, an unlit one the inverse.
    always_comb begin
        o_res.led_levels   = '0;
        o_res.running_mask = '0;
        for (int n = 0; n < OUT_W; n++) begin
            if (n < NUM_LEDS) begin
                o_res.led_levels[n]   = ~(r_lit[n] ^ i_cfg.active_high[n]);
                o_res.running_mask[n] = r_run[n];
            end
        end
        o_res.status = r_status;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    // A tick step load always follows the LED visit that issued its read.
    a_tload_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TLOAD) |-> ($past(r_state) == S_TICK))
        else $error("tick load without a preceding LED visit");

    // A start load always follows the accepted start request.
    a_sload_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOAD) |-> ($past(r_state) == S_IDLE) && $past(i_accept))
        else $error("start load without an accepted request");

    // Step table writes happen only when a request is taken.
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> (i_accept && (r_state == S_IDLE)))
        else $error("step memory written outside a request");

    // A started LED is running when its first step is loaded.
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOAD) |-> r_run[r_cur])
        else $error("started LED not marked running");

endmodule

`default_nettype wire

// ===== sv/led_pattern_sequencer.sv =====
// LED pattern sequencer top level over lps_pkg, lps_ctrl and lps_step_mem.
// A stop, write or rejected start goes straight to S_DONE; a start first loads its step in S_SLOAD.
// A tick visits each LED in S_TICK, with an S_TLOAD visit for each LED that enters a new step,
// since each such LED reads the single step memory port in turn. Each result is then registered.
// A new request is taken once the sequencer is back in S_IDLE; the next may be taken while a result waits.
// Synchronous active-low reset stops all LEDs, empties all patterns; step table undefined.
`default_nettype none

module led_pattern_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [4:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [1:0]  i_led_index,
    input  wire logic [2:0]  i_pattern_index,
    input  wire logic [3:0]  i_step_index,
    input  wire logic        i_step_on,
    input  wire logic [15:0] i_duration_ms,
    input  wire logic [4:0]  i_step_count,
    input  wire logic        i_repeats,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_led_levels,
    output logic [3:0]       o_running_mask,
    output logic [1:0]       o_status
);
    import lps_pkg::*;

    logic [SCALE_W-1:0] r_ticks;
    logic [OUT_W-1:0]   r_mask;
    logic               r_out_valid;
    t_result            r_out;

    t_cfg     cfg;
    t_result  res;
    t_mem_req mem_req;
    t_step    mem_rdata;
    logic     ctrl_idle;
    logic     res_valid;
    logic     res_take;
    logic     in_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= SCALE_W'(1);
            r_mask  <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICKS: r_ticks <= i_cfg_wdata;
                CFG_MASK:  r_mask  <= i_cfg_wdata[OUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Tick scale is clamped to the range 1 to 16.
    always_comb begin
        priority if (r_ticks == '0) begin
            cfg.tick_scale = SCALE_W'(1);
        end else if (r_ticks > SCALE_W'(16)) begin
            cfg.tick_scale = SCALE_W'(16);
        end else begin
            cfg.tick_scale = r_ticks;
        end
        cfg.active_high = r_mask;
    end

    assign o_stall   = !ctrl_idle;
    assign in_accept = i_valid && ctrl_idle;
    assign res_take  = !r_out_valid || !i_stall;

    // Output register between the sequencer and the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_led_levels   = r_out.led_levels;
    assign o_running_mask = r_out.running_mask;
    assign o_status       = r_out.status;

    lps_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_accept        (in_accept),
        .i_cmd           (i_cmd),
        .i_led_index     (i_led_index),
        .i_pattern_index (i_pattern_index),
        .i_step_index    (i_step_index),
        .i_step_on       (i_step_on),
        .i_duration_ms   (i_duration_ms),
        .i_step_count    (i_step_count),
        .i_repeats       (i_repeats),
        .i_res_take      (res_take),
        .o_idle          (ctrl_idle),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .o_mem_req       (mem_req),
        .i_mem_rdata     (mem_rdata)
    );

    lps_step_mem u_step_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
